// ===== rtl/ppd_pkg.sv =====
// Package for the phase pattern detector.
// Holds the reference phase patterns, frame constants and the result type.
// No dependencies.
package ppd_pkg;

    localparam int SYMBOLS = 24;
    localparam int DIFFS = SYMBOLS - 1;
    localparam int PATTERNS = 4;
    localparam int PAT_W = 2;
    localparam int CNT_W = 5;
    localparam int GRAY_W = 2;
    localparam int ERR_W = 16;

    // Difference positions that contribute nothing to the sums.
    localparam logic [CNT_W-1:0] PAUSE_POS_A = CNT_W'(5);
    localparam logic [CNT_W-1:0] PAUSE_POS_B = CNT_W'(11);
    localparam logic [CNT_W-1:0] PAUSE_POS_C = CNT_W'(17);

    // Quarter-turn codes: zero, plus a quarter, half turn, minus a quarter.
    typedef logic [1:0] quarter_t;

    localparam quarter_t QTR_ZERO = 2'd0;
    localparam quarter_t QTR_PLUS = 2'd1;
    localparam quarter_t QTR_HALF = 2'd2;
    localparam quarter_t QTR_MINUS = 2'd3;

    localparam quarter_t REF_QUARTER [PATTERNS][DIFFS] = '{
        '{QTR_ZERO, QTR_ZERO, QTR_ZERO, QTR_HALF, QTR_ZERO, QTR_HALF, QTR_HALF, QTR_ZERO,
          QTR_HALF, QTR_HALF, QTR_HALF, QTR_ZERO, QTR_ZERO, QTR_ZERO, QTR_ZERO, QTR_HALF,
          QTR_ZERO, QTR_HALF, QTR_HALF, QTR_ZERO, QTR_HALF, QTR_HALF, QTR_HALF},
        '{QTR_PLUS, QTR_PLUS, QTR_PLUS, QTR_MINUS, QTR_PLUS, QTR_ZERO, QTR_MINUS, QTR_PLUS,
          QTR_MINUS, QTR_MINUS, QTR_MINUS, QTR_ZERO, QTR_PLUS, QTR_PLUS, QTR_PLUS, QTR_MINUS,
          QTR_PLUS, QTR_ZERO, QTR_MINUS, QTR_PLUS, QTR_MINUS, QTR_MINUS, QTR_MINUS},
        '{QTR_HALF, QTR_HALF, QTR_HALF, QTR_ZERO, QTR_HALF, QTR_HALF, QTR_ZERO, QTR_HALF,
          QTR_ZERO, QTR_ZERO, QTR_ZERO, QTR_ZERO, QTR_HALF, QTR_HALF, QTR_HALF, QTR_ZERO,
          QTR_HALF, QTR_HALF, QTR_ZERO, QTR_HALF, QTR_ZERO, QTR_ZERO, QTR_ZERO},
        '{QTR_MINUS, QTR_MINUS, QTR_MINUS, QTR_PLUS, QTR_MINUS, QTR_ZERO, QTR_PLUS,
          QTR_MINUS, QTR_PLUS, QTR_PLUS, QTR_PLUS, QTR_ZERO, QTR_MINUS, QTR_MINUS,
          QTR_MINUS, QTR_PLUS, QTR_MINUS, QTR_ZERO, QTR_PLUS, QTR_MINUS, QTR_PLUS,
          QTR_PLUS, QTR_PLUS}
    };

    typedef struct packed {
        logic [GRAY_W-1:0] pattern_gray;
        logic [ERR_W-1:0]  best_error;
    } ppd_result_t;

    function automatic quarter_t ref_quarter(input logic [PAT_W-1:0] pat,
                                             input logic [CNT_W-1:0] pos);
        quarter_t code;
        code = QTR_ZERO;
        if (pos < CNT_W'(DIFFS))
        begin
            code = REF_QUARTER[pat][pos];
        end
        return code;
    endfunction

endpackage

// ===== rtl/ppd_if.sv =====
// Channel interfaces of the phase pattern detector: symbol input and result output.
// Depends on ppd_pkg for the result field widths.
interface phase_sym_if #(parameter int ANGLE_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] phase;
    logic                  restart;

    modport source (output valid, output phase, output restart, input ready);
    modport sink (input valid, input phase, input restart, output ready);
endinterface

interface pattern_res_if;
    import ppd_pkg::*;
    logic              valid;
    logic              ready;
    logic [GRAY_W-1:0] pattern_gray;
    logic [ERR_W-1:0]  best_error;

    modport source (output valid, output pattern_gray, output best_error, input ready);
    modport sink (input valid, input pattern_gray, input best_error, output ready);
endinterface

// ===== rtl/ppd_select.sv =====
// Picks the pattern with the smallest absolute error sum and forms the result beat.
// Depends on ppd_pkg.
module ppd_select
    import ppd_pkg::*;
#(
    parameter int SUM_W = 17
)
(
    input  logic [PATTERNS-1:0][SUM_W-1:0] sums,
    output ppd_result_t                    result
);

    localparam int EXT_W = (SUM_W > ERR_W) ? SUM_W : ERR_W + 1;

    logic [PATTERNS-1:0][SUM_W-1:0] mag;
    logic                           lo_pick;
    logic                           hi_pick;
    logic                           top_pick;
    logic [SUM_W-1:0]               lo_mag;
    logic [SUM_W-1:0]               hi_mag;
    logic [SUM_W-1:0]               best_mag;
    logic [PAT_W-1:0]               lo_idx;
    logic [PAT_W-1:0]               hi_idx;
    logic [PAT_W-1:0]               best_idx;
    logic [EXT_W-1:0]               mag_ext;

    always_comb
    begin
        for (int p = 0; p < PATTERNS; p++)
        begin
            mag[p] = sums[p][SUM_W-1] ? (~sums[p] + SUM_W'(1)) : sums[p];
        end

        // Strict compares keep the lower index on a tie.
        lo_pick = mag[1] < mag[0];
        lo_mag = lo_pick ? mag[1] : mag[0];
        lo_idx = lo_pick ? PAT_W'(1) : PAT_W'(0);
        hi_pick = mag[3] < mag[2];
        hi_mag = hi_pick ? mag[3] : mag[2];
        hi_idx = hi_pick ? PAT_W'(3) : PAT_W'(2);
        top_pick = hi_mag < lo_mag;
        best_mag = top_pick ? hi_mag : lo_mag;
        best_idx = top_pick ? hi_idx : lo_idx;

        mag_ext = EXT_W'(best_mag);
        result.pattern_gray = GRAY_W'(best_idx ^ (best_idx >> 1));
        if (|mag_ext[EXT_W-1:ERR_W])
        begin
            result.best_error = '1;
        end
        else
        begin
            result.best_error = mag_ext[ERR_W-1:0];
        end
    end

endmodule

// ===== rtl/phase_pattern_detector_core.sv =====
// Top level of the phase pattern detector: input register, four error accumulators,
// frame result register and output register. Depends on ppd_pkg, ppd_if and ppd_select.
//
//   Channel | Direction | Beat contents          | Handshake
//   sym     | in        | phase, restart         | valid / ready
//   res     | out       | pattern_gray, best_err | valid / ready
//
// One symbol beat is taken every cycle unless the result path stalls; the four pattern sums update in parallel.
// A frame's result passes the input, frame result and output registers in that order.
// Reset clears the frame count, the sums and all valid flags.
// A stalled result stops the symbol path only once a second frame result is waiting.
module phase_pattern_detector_core
    import ppd_pkg::*;
#(
    parameter int ANGLE_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    phase_sym_if.sink            sym,
    pattern_res_if.source        res
);

    localparam int SUM_W = ANGLE_BITS + 5;

    logic                           a_valid_reg;
    logic [ANGLE_BITS-1:0]          a_phase_reg;
    logic                           a_restart_reg;
    logic [ANGLE_BITS-1:0]          prev_phase_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [PATTERNS-1:0][SUM_W-1:0] sum_reg;
    logic [PATTERNS-1:0][SUM_W-1:0] sum_next;
    logic                           fin_valid_reg;
    logic [PATTERNS-1:0][SUM_W-1:0] fin_sum_reg;
    logic                           out_valid_reg;
    ppd_result_t                    out_reg;
    ppd_result_t                    sel_result;

    logic                           out_free;
    logic                           fin_free;
    logic                           a_fire;
    logic                           frame_start;
    logic                           frame_done;
    logic                           skip_pos;
    logic [CNT_W-1:0]               diff_pos;
    logic [ANGLE_BITS-1:0]          diff;
    logic [ANGLE_BITS-1:0]          ref_ang;
    logic [ANGLE_BITS-1:0]          err;

    assign out_free = !out_valid_reg || res.ready;
    assign fin_free = !fin_valid_reg || out_free;
    assign a_fire = a_valid_reg && fin_free;
    assign sym.ready = !a_valid_reg || fin_free;

    always_comb
    begin
        frame_start = a_restart_reg || (count_reg == '0) || (count_reg >= CNT_W'(SYMBOLS));
        diff_pos = count_reg - CNT_W'(1);
        diff = a_phase_reg - prev_phase_reg;
        skip_pos = (diff_pos == PAUSE_POS_A) || (diff_pos == PAUSE_POS_B)
                || (diff_pos == PAUSE_POS_C) || (diff_pos >= CNT_W'(DIFFS));
        count_next = frame_start ? CNT_W'(1) : count_reg + CNT_W'(1);
        frame_done = !frame_start && (count_next == CNT_W'(SYMBOLS));
        ref_ang = '0;
        err = '0;
        for (int p = 0; p < PATTERNS; p++)
        begin
            ref_ang = {ref_quarter(PAT_W'(p), diff_pos), {(ANGLE_BITS - 2){1'b0}}};
            err = ref_ang - diff;
            if (frame_start)
            begin
                sum_next[p] = '0;
            end
            else if (skip_pos)
            begin
                sum_next[p] = sum_reg[p];
            end
            else
            begin
                sum_next[p] = sum_reg[p] + {{(SUM_W - ANGLE_BITS){err[ANGLE_BITS-1]}}, err};
            end
        end
    end

    ppd_select #(
        .SUM_W (SUM_W)
    ) u_select (
        .sums   (fin_sum_reg),
        .result (sel_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            prev_phase_reg <= '0;
            count_reg <= '0;
            sum_reg <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sym.ready)
            begin
                a_valid_reg <= sym.valid;
            end

            if (a_fire)
            begin
                prev_phase_reg <= a_phase_reg;
                sum_reg <= sum_next;
                count_reg <= frame_done ? '0 : count_next;
            end

            if (a_fire && frame_done)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_valid_reg && out_free)
            begin
                fin_valid_reg <= 1'b0;
            end

            if (fin_valid_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym.valid && sym.ready)
        begin
            a_phase_reg <= sym.phase;
            a_restart_reg <= sym.restart;
        end
        if (a_fire && frame_done)
        begin
            fin_sum_reg <= sum_next;
        end
        if (fin_valid_reg && out_free)
        begin
            out_reg <= sel_result;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.pattern_gray = out_reg.pattern_gray;
    assign res.best_error = out_reg.best_error;

endmodule
